@@ design/mbe_pkg.sv @@
// Shared types, constants and rate tables for the meteor/breath light-effect block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mbe_pkg;

    localparam int LED_COUNT_DEF   = 6;
    localparam int LED_COUNT_MAX   = 16;
    localparam int POS_W           = 5;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 8;
    localparam int STEP_W          = 6;
    localparam int WAIT_W          = 8;
    localparam int PROD_W          = 14;
    localparam int RECIP_W         = 16;
    localparam int RECIP_SHIFT     = 20;

    // effect modes
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_METEOR = 2'd1;
    localparam logic [1:0] MODE_BREATH = 2'd2;

    // speed codes
    localparam logic [1:0] SPEED_SLOW   = 2'd0;
    localparam logic [1:0] SPEED_MEDIUM = 2'd1;
    localparam logic [1:0] SPEED_FAST   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BREATH_LED = 3'd5;

    // ceil(2^20 / N): exact floor division for any dividend below 2^14
    localparam int RECIP_SLOW   = ((1 << RECIP_SHIFT) + 50 - 1) / 50;
    localparam int RECIP_MEDIUM = ((1 << RECIP_SHIFT) + 35 - 1) / 35;
    localparam int RECIP_FAST   = ((1 << RECIP_SHIFT) + 25 - 1) / 25;

    typedef enum logic [1:0]
    {
        KIND_RESTART,
        KIND_METEOR,
        KIND_BREATH
    } kind_t;

    typedef enum logic [2:0]
    {
        B_IDLE,
        B_RUN,
        B_MUL,
        B_DIV,
        B_OUT
    } back_state_t;

    typedef struct packed
    {
        logic [1:0] mode;
        logic [1:0] speed;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [2:0] breath_led;
    } cfg_t;

    typedef struct packed
    {
        kind_t             kind;
        logic [POS_W-1:0]  pos;
        logic [1:0]        speed;
        logic [STEP_W-1:0] step;
        logic [2:0]        led;
    } frame_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [WAIT_W-1:0] period_m1(input logic [1:0] speed);
        logic [WAIT_W-1:0] v;
        unique case (speed)
            SPEED_SLOW:   v = 8'd199;
            SPEED_MEDIUM: v = 8'd139;
            default:      v = 8'd79;
        endcase
        return v;
    endfunction

    function automatic logic [STEP_W-1:0] breath_count(input logic [1:0] speed);
        logic [STEP_W-1:0] v;
        unique case (speed)
            SPEED_SLOW:   v = 6'd50;
            SPEED_MEDIUM: v = 6'd35;
            default:      v = 6'd25;
        endcase
        return v;
    endfunction

    function automatic logic [RECIP_W-1:0] breath_recip(input logic [1:0] speed);
        logic [RECIP_W-1:0] v;
        unique case (speed)
            SPEED_SLOW:   v = RECIP_W'(RECIP_SLOW);
            SPEED_MEDIUM: v = RECIP_W'(RECIP_MEDIUM);
            default:      v = RECIP_W'(RECIP_FAST);
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ design/mbe_queue.sv @@
// Short frame queue between the tick front end and the LED write sequencer.
// Depends on mbe_pkg for the frame descriptor and status types.
`default_nettype none

module mbe_queue #(
    parameter int DEPTH = mbe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire mbe_pkg::frame_t push_entry,
    input  wire logic            pop,
    output mbe_pkg::frame_t      pop_entry,
    output mbe_pkg::q_stat_t     stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mbe_pkg::frame_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

@@ design/mbe_front.sv @@
// Front end: configuration registers, tick acceptance, frame timing and phase state.
// Classifies each tick and queues a frame descriptor; depends on mbe_pkg.
`default_nettype none

module mbe_front #(
    parameter int LED_COUNT = mbe_pkg::LED_COUNT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [mbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mbe_pkg::CFG_DATA_W-1:0]  cfg_data,
    output mbe_pkg::cfg_t                        cfg,
    input  wire mbe_pkg::q_stat_t                q_stat,
    output logic                                 push,
    output mbe_pkg::frame_t                      push_entry
);

    localparam int POS_W  = mbe_pkg::POS_W;
    localparam int STEP_W = mbe_pkg::STEP_W;
    localparam int WAIT_W = mbe_pkg::WAIT_W;

    mbe_pkg::cfg_t     cfg_reg, cfg_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [POS_W-1:0]  head_reg, head_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              falling_reg, falling_next;

    logic              accept;
    logic [STEP_W-1:0] count_n;
    logic [STEP_W-1:0] step_shown;
    logic              led_in_range;

    assign s_tready  = !q_stat.full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign cfg       = cfg_reg;

    // config write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                mbe_pkg::REG_MODE:       cfg_next.mode  = cfg_data[1:0];
                mbe_pkg::REG_SPEED:      cfg_next.speed = (cfg_data[1:0] > mbe_pkg::SPEED_FAST)
                                                          ? mbe_pkg::SPEED_FAST : cfg_data[1:0];
                mbe_pkg::REG_RED:        cfg_next.red   = cfg_data[7:0];
                mbe_pkg::REG_GREEN:      cfg_next.green = cfg_data[7:0];
                mbe_pkg::REG_BLUE:       cfg_next.blue  = cfg_data[7:0];
                mbe_pkg::REG_BREATH_LED: cfg_next.breath_led = cfg_data[2:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    assign count_n      = mbe_pkg::breath_count(cfg_reg.speed);
    assign step_shown   = (step_reg > count_n) ? count_n : step_reg;
    assign led_in_range = ({2'b00, cfg_reg.breath_led} <= POS_W'(LED_COUNT));

    // tick classification and phase update
    always_comb
    begin
        wait_next        = wait_reg;
        head_next        = head_reg;
        step_next        = step_reg;
        falling_next     = falling_reg;
        push             = 1'b0;
        push_entry.kind  = mbe_pkg::KIND_RESTART;
        push_entry.pos   = head_reg;
        push_entry.speed = cfg_reg.speed;
        push_entry.step  = step_shown;
        push_entry.led   = cfg_reg.breath_led;
        if (accept)
        begin
            if (s_tdata[0])
            begin
                wait_next    = '0;
                head_next    = POS_W'(1);
                step_next    = '0;
                falling_next = 1'b0;
                push         = 1'b1;
            end
            else if (cfg_reg.mode == mbe_pkg::MODE_METEOR || cfg_reg.mode == mbe_pkg::MODE_BREATH)
            begin
                if (wait_reg != '0)
                begin
                    wait_next = wait_reg - WAIT_W'(1);
                end
                else if (cfg_reg.mode == mbe_pkg::MODE_METEOR)
                begin
                    wait_next       = mbe_pkg::period_m1(cfg_reg.speed);
                    head_next       = (head_reg >= POS_W'(LED_COUNT)) ? POS_W'(1)
                                                                      : head_reg + POS_W'(1);
                    push            = 1'b1;
                    push_entry.kind = mbe_pkg::KIND_METEOR;
                end
                else
                begin
                    wait_next       = WAIT_W'(count_n - STEP_W'(1));
                    push            = led_in_range;
                    push_entry.kind = mbe_pkg::KIND_BREATH;
                    if (falling_reg)
                    begin
                        if (step_shown <= STEP_W'(2))
                        begin
                            step_next    = STEP_W'(1);
                            falling_next = 1'b0;
                        end
                        else
                        begin
                            step_next = step_shown - STEP_W'(1);
                        end
                    end
                    else if (({1'b0, step_reg} + 7'd1) >= {1'b0, count_n})
                    begin
                        step_next    = count_n;
                        falling_next = 1'b1;
                    end
                    else
                    begin
                        step_next = step_reg + STEP_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= '0;
            wait_reg    <= '0;
            head_reg    <= POS_W'(1);
            step_reg    <= '0;
            falling_reg <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            wait_reg    <= wait_next;
            head_reg    <= head_next;
            step_reg    <= step_next;
            falling_reg <= falling_next;
        end
    end

endmodule

`default_nettype wire

@@ design/mbe_back.sv @@
// Back end: expands queued frame descriptors into LED writes on the output stream.
// Meteor frames walk back from the head; breath frames scale via reciprocal multiply.
// Depends on mbe_pkg.
`default_nettype none

module mbe_back #(
    parameter int LED_COUNT = mbe_pkg::LED_COUNT_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mbe_pkg::cfg_t     cfg,
    input  wire mbe_pkg::q_stat_t  q_stat,
    output logic                   pop,
    input  wire mbe_pkg::frame_t   pop_entry,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,
    output logic                   m_tlast
);

    localparam int POS_W   = mbe_pkg::POS_W;
    localparam int PROD_W  = mbe_pkg::PROD_W;
    localparam int RECIP_W = mbe_pkg::RECIP_W;
    localparam int FULL_W  = PROD_W + RECIP_W;
    localparam int DARK_N  = ((LED_COUNT - 3) > 3) ? 3 : (LED_COUNT - 3);
    localparam logic [2:0] METEOR_LAST = 3'(2 + DARK_N);

    mbe_pkg::back_state_t state_reg, state_next;
    mbe_pkg::frame_t      ent_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [2:0]           idx_reg;
    logic [PROD_W-1:0]    prod_reg [3];
    logic [7:0]           quo_reg  [3];

    logic                 out_valid_reg;
    logic [2:0]           out_led_reg;
    logic [7:0]           out_r_reg, out_g_reg, out_b_reg;
    logic                 out_last_reg;

    logic                 out_free;
    logic                 out_load;
    logic [2:0]           load_led;
    logic [7:0]           load_r, load_g, load_b;
    logic                 load_last;
    logic                 run_last;
    logic [2:0]           shift_amt;
    logic [7:0]           colour [3];
    logic [PROD_W-1:0]    prod_next [3];
    logic [7:0]           quo_next  [3];
    logic [FULL_W-1:0]    full_prod [3];
    logic [RECIP_W-1:0]   recip;

    assign out_free  = !out_valid_reg || m_tready;
    assign run_last  = (ent_reg.kind == mbe_pkg::KIND_RESTART) || (idx_reg == METEOR_LAST);
    assign colour[0] = cfg.red;
    assign colour[1] = cfg.green;
    assign colour[2] = cfg.blue;
    assign recip     = mbe_pkg::breath_recip(ent_reg.speed);

    // breath scaling lanes: colour*step, then floor(/N) by reciprocal
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = PROD_W'({6'b0, colour[i]} * {8'b0, ent_reg.step});
            full_prod[i] = {{RECIP_W{1'b0}}, prod_reg[i]} * {{PROD_W{1'b0}}, recip};
            quo_next[i]  = full_prod[i][mbe_pkg::RECIP_SHIFT +: 8];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mbe_pkg::B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = (pop_entry.kind == mbe_pkg::KIND_BREATH) ? mbe_pkg::B_MUL
                                                                           : mbe_pkg::B_RUN;
                end
            end
            mbe_pkg::B_RUN:
            begin
                if (out_free && run_last)
                begin
                    state_next = mbe_pkg::B_IDLE;
                end
            end
            mbe_pkg::B_MUL: state_next = mbe_pkg::B_DIV;
            mbe_pkg::B_DIV: state_next = mbe_pkg::B_OUT;
            mbe_pkg::B_OUT:
            begin
                if (out_free)
                begin
                    state_next = mbe_pkg::B_IDLE;
                end
            end
            default: state_next = mbe_pkg::B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop       = 1'b0;
        out_load  = 1'b0;
        load_led  = pos_reg[2:0];
        load_r    = '0;
        load_g    = '0;
        load_b    = '0;
        load_last = 1'b0;
        shift_amt = (idx_reg == 3'd1) ? 3'd3 + {1'b0, ent_reg.speed}
                                      : 3'd4 + {1'b0, ent_reg.speed};
        unique case (state_reg)
            mbe_pkg::B_IDLE:
            begin
                pop = !q_stat.empty;
            end
            mbe_pkg::B_RUN:
            begin
                out_load  = out_free;
                load_last = run_last;
                if (ent_reg.kind == mbe_pkg::KIND_RESTART)
                begin
                    load_led = 3'd0;
                end
                else if (idx_reg == 3'd0)
                begin
                    load_r = cfg.red;
                    load_g = cfg.green;
                    load_b = cfg.blue;
                end
                else if (idx_reg == 3'd1 || idx_reg == 3'd2)
                begin
                    load_r = cfg.red   >> shift_amt;
                    load_g = cfg.green >> shift_amt;
                    load_b = cfg.blue  >> shift_amt;
                end
            end
            mbe_pkg::B_OUT:
            begin
                out_load  = out_free;
                load_led  = ent_reg.led;
                load_r    = quo_reg[0];
                load_g    = quo_reg[1];
                load_b    = quo_reg[2];
                load_last = 1'b1;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbe_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_reg <= pop_entry;
            pos_reg <= pop_entry.pos;
            idx_reg <= '0;
        end
        else if (state_reg == mbe_pkg::B_RUN && out_free)
        begin
            idx_reg <= idx_reg + 3'd1;
            pos_reg <= (pos_reg == POS_W'(1)) ? POS_W'(LED_COUNT) : pos_reg - POS_W'(1);
        end
        if (state_reg == mbe_pkg::B_MUL)
        begin
            prod_reg <= prod_next;
        end
        if (state_reg == mbe_pkg::B_DIV)
        begin
            quo_reg <= quo_next;
        end
        if (out_load)
        begin
            out_led_reg  <= load_led;
            out_r_reg    <= load_r;
            out_g_reg    <= load_g;
            out_b_reg    <= load_b;
            out_last_reg <= load_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_b_reg, out_g_reg, out_r_reg, out_led_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ design/rgb_meteor_breath_effect_top.sv @@
// Top level of the meteor/breath light-effect generator for a ring of RGB LEDs.
// Instantiates mbe_front, mbe_queue and mbe_back; depends on mbe_pkg.
//
// Usage:
//   s_* channel  : one item per 1 ms tick. s_tdata[0] = restart; a restart blanks
//                  all LEDs (one write, led_select 0) and rewinds the effect phase.
//   cfg_* channel: register writes (0 mode, 1 speed, 2..4 red/green/blue,
//                  5 breath LED). Always ready; write only while the block is idle.
//   m_* channel  : one LED write per item: led_select, red, green, blue in
//                  m_tdata, frame_end on m_tlast (latch the LEDs).
// Path: a tick that starts a meteor frame is written into the frame queue, picked up
//   by the sequencer in its idle state and issued from its run state; a breath frame
//   scales the colour through two multiplier stages before its write is issued.
// Throughput: the write sequencer issues one LED write per cycle while m_tready does
//   not hold the output, and picks up a frame only when the last one is done; a six-LED
//   meteor frame has six writes, a breath frame one. A tick with no frame queues nothing.
// Stall: when m_tready is low the output register holds its item, the sequencer
//   waits, and the two-entry frame queue absorbs further ticks until it is full;
//   only then does s_tready drop.
// Reset: the state and configuration registers clear (mode off), the head returns to LED 1 and the next
//   tick in an active mode runs a frame at once. No clearing pass is needed.
`default_nettype none

module rgb_meteor_breath_effect_top #(
    parameter int LED_COUNT   = mbe_pkg::LED_COUNT_DEF,
    parameter int QUEUE_DEPTH = mbe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // tick stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [0] restart
    // register write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [mbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mbe_pkg::CFG_DATA_W-1:0]  cfg_data,
    // LED write stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [31:0]                          m_tdata,   // [2:0] led_select, [10:3] red,
                                                            // [18:11] green, [26:19] blue
    output logic                                 m_tlast    // frame_end
);

    mbe_pkg::cfg_t    cfg;
    mbe_pkg::q_stat_t q_stat;
    mbe_pkg::frame_t  push_entry;
    mbe_pkg::frame_t  pop_entry;
    logic             push;
    logic             pop;

    // accept ticks, keep phase, queue frame descriptors
    mbe_front #(
        .LED_COUNT (LED_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    // decouple tick acceptance from LED write issue
    mbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .stat       (q_stat)
    );

    // expand each frame into LED writes
    mbe_back #(
        .LED_COUNT (LED_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_stat    (q_stat),
        .pop       (pop),
        .pop_entry (pop_entry),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // front never queues a frame into a full queue
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("frame pushed into full queue");

    // sequencer only picks up a frame that is there
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("frame popped from empty queue");

    // a queued frame is always held until the sequencer takes it
    a_queue_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_stat.empty && !pop) |=> !q_stat.empty)
        else $error("queued frame lost");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the meteor/breath light-effect top level.
// Predicts every LED write from the tick stream and register writes; needs mbe_pkg.

module tb_top;

    // Codes the block must tolerate but the package does not name.
    localparam logic [1:0] MODE_UNUSED = 2'd3;   // behaves as off
    localparam logic [1:0] SPEED_OVER  = 2'd3;   // saturates to fast
    localparam logic [7:0] LED_NONE    = 8'd7;   // beyond the ring: no write

    localparam int LEDS        = mbe_pkg::LED_COUNT_DEF;
    localparam int DRAIN_HOLD  = 12;             // covers a breath frame still in its multiply and divide states
    localparam int CYCLE_LIMIT = 1_000_000;

    // One LED write as the block reports it.
    typedef struct packed
    {
        logic [2:0] led;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } led_write_t;

    localparam led_write_t ALL_DARK = '{3'd0, 8'd0, 8'd0, 8'd0, 1'b1};

    // One row of the directed table: a register write or a tick.
    typedef struct
    {
        bit              is_reg;
        logic [2:0]      idx;
        logic [7:0]      data;
        logic            restart;
        bit              typed;
        led_write_t      want;
    } script_row_t;

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata = 8'd0;      // [0] restart
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [31:0]                    m_tdata;             // [2:0] led, [10:3] red,
                                                         // [18:11] green, [26:19] blue
    logic                           m_tlast;             // frame_end

    rgb_meteor_breath_effect_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // ------------------------------------------------------------------
    // Effect predictor: its own copy of the registers and the phase state.
    // ------------------------------------------------------------------
    logic [1:0] fx_mode  = mbe_pkg::MODE_OFF;
    logic [1:0] fx_speed = mbe_pkg::SPEED_SLOW;
    logic [7:0] fx_red   = 8'd0;
    logic [7:0] fx_green = 8'd0;
    logic [7:0] fx_blue  = 8'd0;
    logic [2:0] fx_led   = 3'd0;

    logic [7:0] ticks_to_frame = 8'd0;
    logic [2:0] head_pos       = 3'd1;
    logic [5:0] ramp_step      = 6'd0;
    bit         ramp_falling   = 1'b0;

    led_write_t frame_writes[$];     // writes caused by the latest tick
    led_write_t led_writes_due[$];   // writes still to come out of the block

    int         mismatches = 0;
    int         cycle_count = 0;
    int         tx_idle_pct = 14;
    int         rx_idle_pct = 69;

    // LED number 'back' places behind the head, wrapping around the ring.
    function automatic logic [2:0] ring_back(input int back);
        return 3'(((int'(head_pos) - 1 + 2 * LEDS - back) % LEDS) + 1);
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [7:0] data);
        case (idx)
            mbe_pkg::REG_MODE:       fx_mode  = data[1:0];
            mbe_pkg::REG_SPEED:      fx_speed = (data[1:0] > mbe_pkg::SPEED_FAST)
                                                ? mbe_pkg::SPEED_FAST : data[1:0];
            mbe_pkg::REG_RED:        fx_red   = data;
            mbe_pkg::REG_GREEN:      fx_green = data;
            mbe_pkg::REG_BLUE:       fx_blue  = data;
            mbe_pkg::REG_BREATH_LED: fx_led   = data[2:0];
            default:                 ;
        endcase
    endfunction

    function automatic void meteor_frame();
        led_write_t w;
        int         sp;
        int         dark;
        int         k;
        sp = int'(fx_speed);
        case (fx_speed)
            mbe_pkg::SPEED_SLOW:   ticks_to_frame = 8'd199;
            mbe_pkg::SPEED_MEDIUM: ticks_to_frame = 8'd139;
            default:               ticks_to_frame = 8'd79;
        endcase
        // head at full colour, then the two dimmed tail LEDs
        w.led = ring_back(0); w.red = fx_red; w.green = fx_green; w.blue = fx_blue;
        w.last = 1'b0;
        frame_writes.push_back(w);
        w.led = ring_back(1);
        w.red = fx_red >> (3 + sp); w.green = fx_green >> (3 + sp);
        w.blue = fx_blue >> (3 + sp);
        frame_writes.push_back(w);
        w.led = ring_back(2);
        w.red = fx_red >> (4 + sp); w.green = fx_green >> (4 + sp);
        w.blue = fx_blue >> (4 + sp);
        frame_writes.push_back(w);
        // blank up to three LEDs beyond the tail; the last write closes the frame
        dark = (LEDS - 3 > 3) ? 3 : LEDS - 3;
        for (k = 0; k < dark; k++)
        begin
            w.led = ring_back(3 + k);
            w.red = 8'd0; w.green = 8'd0; w.blue = 8'd0;
            w.last = (k == dark - 1);
            frame_writes.push_back(w);
        end
        head_pos = (head_pos >= 3'(LEDS)) ? 3'd1 : head_pos + 3'd1;
    endfunction

    function automatic void breath_frame();
        led_write_t w;
        int         n;
        int         s;
        case (fx_speed)
            mbe_pkg::SPEED_SLOW:   n = 50;
            mbe_pkg::SPEED_MEDIUM: n = 35;
            default:               n = 25;
        endcase
        // a step left above N by a speed change shows as N
        s = (int'(ramp_step) > n) ? n : int'(ramp_step);
        w.led   = fx_led;
        w.red   = 8'((int'(fx_red) * s) / n);
        w.green = 8'((int'(fx_green) * s) / n);
        w.blue  = 8'((int'(fx_blue) * s) / n);
        w.last  = 1'b1;
        ticks_to_frame = 8'(n - 1);
        if (ramp_falling)
        begin
            if (s <= 2)
            begin
                ramp_step    = 6'd1;
                ramp_falling = 1'b0;
            end
            else
                ramp_step = 6'(s - 1);
        end
        else if (int'(ramp_step) + 1 >= n)
        begin
            ramp_step    = 6'(n);
            ramp_falling = 1'b1;
        end
        else
            ramp_step = ramp_step + 6'd1;
        // an LED beyond the ring still advances the phase but gets no write
        if (int'(fx_led) <= LEDS)
            frame_writes.push_back(w);
    endfunction

    // Work out the LED writes that one accepted tick causes.
    function automatic void effect_tick(input logic restart);
        frame_writes.delete();
        if (restart)
        begin
            ticks_to_frame = 8'd0;
            head_pos       = 3'd1;
            ramp_step      = 6'd0;
            ramp_falling   = 1'b0;
            frame_writes.push_back(ALL_DARK);
        end
        else if (fx_mode == mbe_pkg::MODE_METEOR || fx_mode == mbe_pkg::MODE_BREATH)
        begin
            if (ticks_to_frame != 8'd0)
                ticks_to_frame = ticks_to_frame - 8'd1;
            else if (fx_mode == mbe_pkg::MODE_METEOR)
                meteor_frame();
            else
                breath_frame();
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // LED write side: random back-pressure, compare against the oldest write due
    // ------------------------------------------------------------------
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch in %s: got %0d, want %0d (cycle %0d)",
                 what, got, want, cycle_count);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        led_write_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (led_writes_due.size() == 0)
                report_mismatch("unexpected LED write, led", int'(m_tdata[2:0]), -1);
            else
            begin
                want = led_writes_due.pop_front();
                if (m_tdata[2:0] != want.led)
                    report_mismatch("led_select", int'(m_tdata[2:0]), int'(want.led));
                if (m_tdata[10:3] != want.red)
                    report_mismatch("out_red", int'(m_tdata[10:3]), int'(want.red));
                if (m_tdata[18:11] != want.green)
                    report_mismatch("out_green", int'(m_tdata[18:11]), int'(want.green));
                if (m_tdata[26:19] != want.blue)
                    report_mismatch("out_blue", int'(m_tdata[26:19]), int'(want.blue));
                if (m_tlast != want.last)
                    report_mismatch("frame_end", int'(m_tlast), int'(want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Driving tasks; each starts and ends at a falling edge
    // ------------------------------------------------------------------

    // Write one register; the block must be idle.
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Offer one tick, idling first at the sender's rate. s_tvalid stays high
    // afterwards so back-to-back ticks follow without a gap. A typed row pushes
    // its own expectation in place of the predicted one.
    task automatic send_tick(input logic restart, input bit typed, input led_write_t want);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        do @(posedge clk); while (!s_tready);
        effect_tick(restart);
        if (typed)
            led_writes_due.push_back(want);
        else
            foreach (frame_writes[i])
                led_writes_due.push_back(frame_writes[i]);
        @(negedge clk);
    endtask

    // Hold the sender until every due write is out, then let the pipeline
    // settle in case the last tick was still computing a frame with no write.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (led_writes_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_HOLD) @(negedge clk);
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    script_row_t script[$];

    function automatic void add_reg(input logic [2:0] idx, input logic [7:0] data);
        script_row_t r;
        r.is_reg = 1'b1; r.idx = idx; r.data = data;
        r.restart = 1'b0; r.typed = 1'b0; r.want = '0;
        script.push_back(r);
    endfunction

    function automatic void add_tick(input logic restart);
        script_row_t r;
        r.is_reg = 1'b0; r.idx = '0; r.data = '0;
        r.restart = restart; r.typed = 1'b0; r.want = '0;
        script.push_back(r);
    endfunction

    function automatic void add_tick_want(input logic restart, input led_write_t want);
        script_row_t r;
        r.is_reg = 1'b0; r.idx = '0; r.data = '0;
        r.restart = restart; r.typed = 1'b1; r.want = want;
        script.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        bit         prev_reg;
        int         phase;
        int         n_ticks;
        int         pick;
        logic [1:0] mode_sel;

        // Off after reset: a tick writes nothing, a restart still blanks.
        add_tick(1'b0);
        add_tick_want(1'b1, ALL_DARK);
        // Meteor, slow, odd colour: first frame must start at LED 1.
        add_reg(mbe_pkg::REG_MODE, {6'd0, mbe_pkg::MODE_METEOR});
        add_reg(mbe_pkg::REG_SPEED, {6'd0, mbe_pkg::SPEED_SLOW});
        add_reg(mbe_pkg::REG_RED, 8'hFF);
        add_reg(mbe_pkg::REG_GREEN, 8'h80);
        add_reg(mbe_pkg::REG_BLUE, 8'h01);
        add_tick(1'b0);
        add_tick(1'b0);
        add_tick_want(1'b1, ALL_DARK);
        add_tick(1'b0);
        // Speed write above fast saturates; restart rewinds the head.
        add_reg(mbe_pkg::REG_SPEED, {6'd0, SPEED_OVER});
        add_reg(mbe_pkg::REG_RED, 8'h7F);
        add_tick_want(1'b1, ALL_DARK);
        add_tick(1'b0);
        // Breath on all LEDs: the first step after a restart is dark.
        add_reg(mbe_pkg::REG_MODE, {6'd0, mbe_pkg::MODE_BREATH});
        add_reg(mbe_pkg::REG_SPEED, {6'd0, mbe_pkg::SPEED_SLOW});
        add_reg(mbe_pkg::REG_BREATH_LED, 8'd0);
        add_reg(mbe_pkg::REG_RED, 8'hFF);
        add_reg(mbe_pkg::REG_GREEN, 8'hFF);
        add_reg(mbe_pkg::REG_BLUE, 8'hFF);
        add_tick_want(1'b1, ALL_DARK);
        add_tick_want(1'b0, '{3'd0, 8'd0, 8'd0, 8'd0, 1'b1});
        add_tick(1'b0);
        // Last LED of the ring.
        add_reg(mbe_pkg::REG_BREATH_LED, 8'(LEDS));
        add_tick_want(1'b1, ALL_DARK);
        add_tick_want(1'b0, '{3'(LEDS), 8'd0, 8'd0, 8'd0, 1'b1});
        // LED beyond the ring: the frame runs but writes nothing.
        add_reg(mbe_pkg::REG_BREATH_LED, LED_NONE);
        add_tick_want(1'b1, ALL_DARK);
        add_tick(1'b0);
        // Unused mode acts as off.
        add_reg(mbe_pkg::REG_MODE, {6'd0, MODE_UNUSED});
        add_tick(1'b0);
        add_tick_want(1'b1, ALL_DARK);
        add_reg(mbe_pkg::REG_MODE, {6'd0, mbe_pkg::MODE_OFF});
        add_tick(1'b0);

        // Hold reset, then release it at a falling edge.
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        prev_reg = 1'b0;
        foreach (script[i])
        begin
            if (script[i].is_reg)
            begin
                if (!prev_reg)
                    wait_drain();
                write_reg(script[i].idx, script[i].data);
            end
            else
                send_tick(script[i].restart, script[i].typed, script[i].want);
            prev_reg = script[i].is_reg;
        end

        // Random phases: fresh settings each phase, frequent restarts so frames
        // come often; settings change without a restart so the phase carries over.
        for (phase = 0; phase < 9; phase++)
        begin
            if (phase < 3)
            begin
                tx_idle_pct = 14;
                rx_idle_pct = 69;
            end
            else if (phase < 6)
            begin
                tx_idle_pct = 69;
                rx_idle_pct = 14;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            wait_drain();
            pick = $urandom_range(0, 19);
            if (pick == 0)
                mode_sel = mbe_pkg::MODE_OFF;
            else if (pick == 1)
                mode_sel = MODE_UNUSED;
            else if (pick < 10)
                mode_sel = mbe_pkg::MODE_METEOR;
            else
                mode_sel = mbe_pkg::MODE_BREATH;
            write_reg(mbe_pkg::REG_MODE, {6'd0, mode_sel});
            if ($urandom_range(0, 3) != 0)
                write_reg(mbe_pkg::REG_SPEED, 8'($urandom_range(0, 3)));
            if ($urandom_range(0, 3) != 0)
                write_reg(mbe_pkg::REG_RED, pick_level());
            if ($urandom_range(0, 3) != 0)
                write_reg(mbe_pkg::REG_GREEN, pick_level());
            if ($urandom_range(0, 3) != 0)
                write_reg(mbe_pkg::REG_BLUE, pick_level());
            if ($urandom_range(0, 3) != 0)
                write_reg(mbe_pkg::REG_BREATH_LED, 8'($urandom_range(0, 7)));

            n_ticks = (mode_sel == mbe_pkg::MODE_METEOR || mode_sel == mbe_pkg::MODE_BREATH)
                      ? $urandom_range(28, 36) : 10;
            for (int t = 0; t < n_ticks; t++)
            begin
                // now and then hold off until the block has emptied
                if ($urandom_range(0, 39) == 0)
                    wait_drain();
                pick = ($urandom_range(0, 11) == 0);
                send_tick(pick[0], 1'b0, '0);
            end
        end

        wait_drain();
        if (mismatches == 0 && led_writes_due.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
design/mbe_pkg.sv
design/mbe_queue.sv
design/mbe_front.sv
design/mbe_back.sv
design/rgb_meteor_breath_effect_top.sv
dv/tb_top.sv
